>>> src/mvdi_pkg.sv
package mvdi_pkg;

  localparam int unsigned FIELD_W = 20;
  localparam int unsigned SLOT_W = 16;
  localparam logic [SLOT_W-1:0] SLOT_SAT = 16'hFFFF;

  localparam logic OP_CORNER = 1'b0;
  localparam logic OP_END = 1'b1;

  typedef struct packed {
    logic               op;
    logic               start_of_face;
    logic [FIELD_W-1:0] position_index;
    logic [FIELD_W-1:0] texcoord_index;
    logic [FIELD_W-1:0] normal_index;
  } in_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  vertex_slot;
    logic               is_new;
    logic [FIELD_W-1:0] out_position;
    logic [FIELD_W-1:0] out_texcoord;
    logic [FIELD_W-1:0] out_normal;
    logic               overflow;
    logic               last;
  } out_word_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_START,
    B_READ,
    B_CHECK,
    B_EMIT
  } back_state_t;

endpackage

>>> src/mvdi_fifo.sv
module mvdi_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == (PW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // store the incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> src/mvdi_front.sv
module mvdi_front #(
  parameter int unsigned INDEX_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  mvdi_pkg::in_word_t    in_data,
  output logic                  in_full,
  output logic                  job_push,
  output logic [9*INDEX_BITS:0] job_data,
  input  logic                  job_full
);
  import mvdi_pkg::*;

  localparam int unsigned CW = 3 * INDEX_BITS;

  logic [31:0]   pos32, tex32, nrm32;
  logic [CW-1:0] cur;
  logic [CW-1:0] first_r, first_nxt;
  logic [CW-1:0] prev_r, prev_nxt;
  logic [1:0]    held_r, held_nxt;
  logic          accept;

  // keep the low index bits of each field
  assign pos32 = 32'(in_data.position_index);
  assign tex32 = 32'(in_data.texcoord_index);
  assign nrm32 = 32'(in_data.normal_index);
  assign cur   = {pos32[INDEX_BITS-1:0], tex32[INDEX_BITS-1:0], nrm32[INDEX_BITS-1:0]};

  assign in_full = job_full;
  assign accept  = in_push && !job_full;

  // classify the word and build the fan
  always_comb begin
    first_nxt = first_r;
    prev_nxt  = prev_r;
    held_nxt  = held_r;
    job_push  = 1'b0;
    job_data  = {1'b0, first_r, prev_r, cur};
    if (accept) begin
      if (in_data.op == OP_END) begin
        job_push  = 1'b1;
        job_data  = {1'b1, first_r, prev_r, cur};
        held_nxt  = 2'd0;
        first_nxt = '0;
        prev_nxt  = '0;
      end else if (in_data.start_of_face || held_r == 2'd0) begin
        first_nxt = cur;
        held_nxt  = 2'd1;
      end else if (held_r == 2'd1) begin
        prev_nxt = cur;
        held_nxt = 2'd2;
      end else begin
        job_push = 1'b1;
        prev_nxt = cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 2'd0;
      first_r <= '0;
      prev_r  <= '0;
    end else begin
      held_r  <= held_nxt;
      first_r <= first_nxt;
      prev_r  <= prev_nxt;
    end
  end

endmodule

>>> src/mvdi_back.sv
module mvdi_back #(
  parameter int unsigned TABLE_DEPTH = 4096,
  parameter int unsigned INDEX_BITS  = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  not_indexed,
  input  logic [9*INDEX_BITS:0] job_data,
  input  logic                  job_empty,
  output logic                  job_pop,
  output mvdi_pkg::out_word_t   res_data,
  output logic                  res_push,
  input  logic                  res_full
);
  import mvdi_pkg::*;

  localparam int unsigned CW = 3 * INDEX_BITS;
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned EW = 1 + CW + SLOT_W;

  logic [EW-1:0] table_mem [TABLE_DEPTH];
  logic [EW-1:0] rdata_r;
  logic          mem_we;
  logic [EW-1:0] mem_wdata;

  back_state_t       state_r, state_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [AW-1:0]     probes_r, probes_nxt;
  logic [SLOT_W-1:0] counter_r, counter_nxt;
  logic              from_job_r, from_job_nxt;
  out_word_t         res_r, res_nxt, res_base;

  logic [CW-1:0]     cur;
  logic [31:0]       pos32, tex32, nrm32;
  logic              ent_valid;
  logic [CW-1:0]     ent_key;
  logic [SLOT_W-1:0] ent_slot;
  logic              cap_idx, cap_seq;
  logic [AW-1:0]     addr_inc;

  // fold the triple into a table address
  function automatic logic [AW-1:0] hash_key(input logic [CW-1:0] key);
    logic [AW-1:0] h;
    h = '0;
    for (int i = 0; i < CW; i++) begin
      h[i % AW] = h[i % AW] ^ key[i];
    end
    if ({1'b0, h} >= (AW+1)'(TABLE_DEPTH)) begin
      h = AW'({1'b0, h} - (AW+1)'(TABLE_DEPTH));
    end
    return h;
  endfunction

  // pick the corner in fan order: first, previous, current
  always_comb begin
    case (idx_r)
      2'd0:    cur = job_data[3*CW-1:2*CW];
      2'd1:    cur = job_data[2*CW-1:CW];
      default: cur = job_data[CW-1:0];
    endcase
  end

  assign pos32 = 32'(cur[CW-1 -: INDEX_BITS]);
  assign tex32 = 32'(cur[2*INDEX_BITS-1 -: INDEX_BITS]);
  assign nrm32 = 32'(cur[INDEX_BITS-1:0]);

  assign ent_valid = rdata_r[EW-1];
  assign ent_key   = rdata_r[EW-2 -: CW];
  assign ent_slot  = rdata_r[SLOT_W-1:0];

  assign cap_seq  = (counter_r != SLOT_SAT);
  assign cap_idx  = cap_seq && ({1'b0, counter_r} < (SLOT_W+1)'(TABLE_DEPTH));
  assign addr_inc = (addr_r == AW'(TABLE_DEPTH-1)) ? '0 : addr_r + 1'b1;

  assign res_data = res_r;

  // common part of a result word
  always_comb begin
    res_base              = '0;
    res_base.vertex_slot  = SLOT_SAT;
    res_base.out_position = pos32[FIELD_W-1:0];
    res_base.out_texcoord = tex32[FIELD_W-1:0];
    res_base.out_normal   = nrm32[FIELD_W-1:0];
    res_base.last         = (idx_r == 2'd2);
  end

  // sequence table sweeps, probes and result words
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    addr_nxt     = addr_r;
    probes_nxt   = probes_r;
    counter_nxt  = counter_r;
    from_job_nxt = from_job_r;
    res_nxt      = res_r;
    mem_we       = 1'b0;
    mem_wdata    = '0;
    job_pop      = 1'b0;
    res_push     = 1'b0;
    case (state_r)
      B_CLEAR: begin
        mem_we = 1'b1;
        if (addr_r == AW'(TABLE_DEPTH-1)) begin
          addr_nxt    = '0;
          counter_nxt = '0;
          job_pop     = from_job_r;
          state_nxt   = B_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      B_IDLE: begin
        if (!job_empty) begin
          if (job_data[9*INDEX_BITS]) begin
            from_job_nxt = 1'b1;
            addr_nxt     = '0;
            state_nxt    = B_CLEAR;
          end else begin
            idx_nxt   = 2'd0;
            state_nxt = B_START;
          end
        end
      end
      B_START: begin
        if (not_indexed) begin
          res_nxt = res_base;
          if (cap_seq) begin
            res_nxt.vertex_slot = counter_r;
            res_nxt.is_new      = 1'b1;
            counter_nxt         = counter_r + 1'b1;
          end else begin
            res_nxt.overflow = 1'b1;
          end
          state_nxt = B_EMIT;
        end else begin
          addr_nxt   = hash_key(cur);
          probes_nxt = '0;
          state_nxt  = B_READ;
        end
      end
      B_READ: begin
        state_nxt = B_CHECK;
      end
      B_CHECK: begin
        res_nxt = res_base;
        if (ent_valid && ent_key == cur) begin
          res_nxt.vertex_slot = ent_slot;
          state_nxt           = B_EMIT;
        end else if (!ent_valid) begin
          if (cap_idx) begin
            mem_we              = 1'b1;
            mem_wdata           = {1'b1, cur, counter_r};
            res_nxt.vertex_slot = counter_r;
            res_nxt.is_new      = 1'b1;
            counter_nxt         = counter_r + 1'b1;
          end else begin
            res_nxt.overflow = 1'b1;
          end
          state_nxt = B_EMIT;
        end else if (probes_r == AW'(TABLE_DEPTH-1)) begin
          res_nxt.overflow = 1'b1;
          state_nxt        = B_EMIT;
        end else begin
          addr_nxt   = addr_inc;
          probes_nxt = probes_r + 1'b1;
          state_nxt  = B_READ;
        end
      end
      B_EMIT: begin
        if (!res_full) begin
          res_push = 1'b1;
          if (idx_r == 2'd2) begin
            job_pop   = 1'b1;
            state_nxt = B_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = B_START;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_CLEAR;
      idx_r      <= 2'd0;
      addr_r     <= '0;
      probes_r   <= '0;
      counter_r  <= '0;
      from_job_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      addr_r     <= addr_nxt;
      probes_r   <= probes_nxt;
      counter_r  <= counter_nxt;
      from_job_r <= from_job_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // table memory: one port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[addr_r] <= mem_wdata;
    end
    rdata_r <= table_mem[addr_r];
  end

endmodule

>>> src/mesh_vertex_dedup_indexer.sv
// Vertex deduplication index builder. Face corners (position, texcoord,
// normal index triples) are pushed one word at a time; faces are fan
// triangulated and every corner from the third of a face on pops out three
// result words (first, previous, current corner) carrying the vertex slot.
// In indexed mode the slot comes from a hashed, linearly probed table of
// TABLE_DEPTH entries in a single-port memory; each triangle corner costs
// a table read and a check per probe, plus a wait while the result queue
// is full. Corners that start a face are absorbed. After reset, and after
// every end-of-object word, the table is swept clean entry by entry, during
// which queued words wait.
// A two-deep job queue and a four-deep result queue decouple the ports.
module mesh_vertex_dedup_indexer #(
  parameter int unsigned TABLE_DEPTH = 4096,
  parameter int unsigned INDEX_BITS  = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  mvdi_pkg::in_word_t  in_data,
  output logic                in_full,
  input  logic                out_pop,
  output mvdi_pkg::out_word_t out_data,
  output logic                out_empty,
  input  logic                cfg_valid,
  input  logic                cfg_data,
  output logic                cfg_ready
);
  import mvdi_pkg::*;

  localparam int unsigned JW = 9 * INDEX_BITS + 1;
  localparam int unsigned OW = $bits(out_word_t);

  logic          mode_r;
  logic          job_push, job_full, job_pop, job_empty;
  logic [JW-1:0] job_wdata, job_rdata;
  out_word_t     res_data;
  logic          res_push, res_full;
  logic [OW-1:0] out_vec;

  // hold the mode register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data;
    end
  end

  mvdi_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .job_push (job_push),
    .job_data (job_wdata),
    .job_full (job_full)
  );

  mvdi_fifo #(.W(JW), .DEPTH(2)) u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_wdata),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_rdata),
    .empty (job_empty)
  );

  mvdi_back #(.TABLE_DEPTH(TABLE_DEPTH), .INDEX_BITS(INDEX_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .not_indexed (mode_r),
    .job_data    (job_rdata),
    .job_empty   (job_empty),
    .job_pop     (job_pop),
    .res_data    (res_data),
    .res_push    (res_push),
    .res_full    (res_full)
  );

  mvdi_fifo #(.W(OW), .DEPTH(4)) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_vec),
    .empty (out_empty)
  );

  assign out_data = out_word_t'(out_vec);

endmodule

>>> src/mvdi_checker.sv
module mvdi_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_push,
  input mvdi_pkg::in_word_t  in_data,
  input logic                in_full,
  input logic                out_pop,
  input mvdi_pkg::out_word_t out_data,
  input logic                out_empty,
  input logic                cfg_valid,
  input logic                cfg_data,
  input logic                cfg_ready
);
  import mvdi_pkg::*;

  logic [1:0] corner_r, corner_nxt;

  // count result words within a triangle
  always_comb begin
    corner_nxt = corner_r;
    if (out_pop && !out_empty) begin
      corner_nxt = (corner_r == 2'd2) ? 2'd0 : corner_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_r <= 2'd0;
    end else begin
      corner_r <= corner_nxt;
    end
  end

  a_empty_after_reset: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> out_empty)
    else $error("results present straight after reset");

  a_last_every_third: assert property (@(posedge clk) disable iff (!rst_n)
    out_pop && !out_empty |-> (out_data.last == (corner_r == 2'd2)))
    else $error("last flag out of step with triangle corners");

  a_overflow_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.overflow |->
      (out_data.vertex_slot == SLOT_SAT) && !out_data.is_new)
    else $error("overflow word without saturated slot");

  a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("waiting result word changed");

endmodule

bind mesh_vertex_dedup_indexer mvdi_checker u_mvdi_checker (.*);

>>> verif/mvdi_checker.sv
module mvdi_scoreboard (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  mvdi_pkg::in_word_t  in_data,
  input  logic                in_full,
  input  logic                out_pop,
  input  mvdi_pkg::out_word_t out_data,
  input  logic                out_empty,
  input  logic                cfg_valid,
  input  logic                cfg_data,
  input  logic                cfg_ready,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mvdi_pkg::*;

  localparam int unsigned TABLE_DEPTH = 4096;

  // Predicted state of the index builder
  bit                   flat_mode;
  int unsigned          next_slot;
  int unsigned          held;
  logic [59:0]          fan_first;
  logic [59:0]          fan_prev;
  int unsigned          slot_of_triple [logic [59:0]];
  out_word_t            slot_words_q [$];

  function automatic void clear_object();
    slot_of_triple.delete();
    next_slot = 0;
    held      = 0;
    fan_first = '0;
    fan_prev  = '0;
  endfunction

  // Look up or allocate the slot of one triangle corner and queue its word
  function automatic void assign_slot(logic [59:0] triple, logic is_last);
    out_word_t w;
    w              = '0;
    w.vertex_slot  = SLOT_SAT;
    w.out_position = triple[59:40];
    w.out_texcoord = triple[39:20];
    w.out_normal   = triple[19:0];
    w.last         = is_last;
    if (!flat_mode && slot_of_triple.exists(triple)) begin
      w.vertex_slot = slot_of_triple[triple];
    end else if (!flat_mode && next_slot < TABLE_DEPTH && next_slot < 65535) begin
      slot_of_triple[triple] = next_slot;
      w.vertex_slot = next_slot;
      w.is_new      = 1'b1;
      next_slot++;
    end else if (flat_mode && next_slot < 65535) begin
      w.vertex_slot = next_slot;
      w.is_new      = 1'b1;
      next_slot++;
    end else begin
      w.overflow = 1'b1;
    end
    slot_words_q.push_back(w);
  endfunction

  function automatic void predict_word(in_word_t iw);
    logic [59:0] cur;
    cur = {iw.position_index, iw.texcoord_index, iw.normal_index};
    if (iw.op == OP_END) begin
      clear_object();
    end else if (iw.start_of_face || held == 0) begin
      fan_first = cur;
      held      = 1;
    end else if (held == 1) begin
      fan_prev = cur;
      held     = 2;
    end else begin
      assign_slot(fan_first, 1'b0);
      assign_slot(fan_prev, 1'b0);
      assign_slot(cur, 1'b1);
      fan_prev = cur;
    end
  endfunction

  function automatic void check_field(string name, logic [19:0] exp_v, logic [19:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // Watch the three channels and compare each popped word with the oldest prediction
  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      clear_object();
      flat_mode = 1'b0;
      slot_words_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) flat_mode = cfg_data;
      if (in_push && !in_full) predict_word(in_data);
      if (out_pop && !out_empty) begin
        if (slot_words_q.size() == 0) begin
          $error("unexpected result word: slot %0h", out_data.vertex_slot);
          fail_count++;
        end else begin
          e = slot_words_q.pop_front();
          check_field("vertex_slot", e.vertex_slot, out_data.vertex_slot);
          check_field("is_new", e.is_new, out_data.is_new);
          check_field("out_position", e.out_position, out_data.out_position);
          check_field("out_texcoord", e.out_texcoord, out_data.out_texcoord);
          check_field("out_normal", e.out_normal, out_data.out_normal);
          check_field("overflow", e.overflow, out_data.overflow);
          check_field("last", e.last, out_data.last);
        end
      end
    end
    pending <= slot_words_q.size();
  end

endmodule

>>> verif/tb_mesh_vertex_dedup_indexer.sv
module tb_mesh_vertex_dedup_indexer;
  timeunit 1ns;
  timeprecision 1ps;
  import mvdi_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  in_word_t  in_data = '0;
  logic      in_full;
  logic      out_pop = 1'b0;
  out_word_t out_data;
  logic      out_empty;
  logic      cfg_valid = 1'b0;
  logic      cfg_data = 1'b0;
  logic      cfg_ready;
  int        fail_count;
  int        pending;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        cycles = 0;

  always #2 clk = ~clk;

  mesh_vertex_dedup_indexer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .out_pop  (out_pop),
    .out_data (out_data),
    .out_empty(out_empty),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .cfg_ready(cfg_ready)
  );

  mvdi_scoreboard u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .out_empty (out_empty),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Stall the result side at random
  always @(negedge clk) begin
    out_pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Guard against a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_word(logic op, logic sof, logic [19:0] p, logic [19:0] t, logic [19:0] n);
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_push <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
    @(negedge clk);
    in_push <= 1'b1;
    in_data <= '{op: op, start_of_face: sof, position_index: p,
                 texcoord_index: t, normal_index: n};
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // Hold off until every slot word has drained, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_mode(logic flat);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= flat;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [19:0] pick_index();
    if ($urandom_range(9) == 0) return 20'($urandom);
    return 20'($urandom_range(5));
  endfunction

  task automatic random_corners(int n_items);
    int i;
    int face_left;
    int r;
    i = 0;
    face_left = 0;
    while (i < n_items) begin
      r = $urandom_range(99);
      if (r < 2) begin
        send_word(OP_END, 1'b0, 20'($urandom), 20'($urandom), 20'($urandom));
        face_left = 0;
      end else if (r < 8) begin
        // stray corner, face state unknown
        send_word(OP_CORNER, 1'($urandom), pick_index(), pick_index(), pick_index());
        i++;
      end else if (face_left == 0) begin
        send_word(OP_CORNER, 1'b1, pick_index(), pick_index(), pick_index());
        face_left = $urandom_range(6, 2);
        i++;
      end else begin
        send_word(OP_CORNER, 1'b0, pick_index(), pick_index(), pick_index());
        face_left--;
        i++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: indexed mode, extremes and corner cases
    write_mode(1'b0);
    send_word(OP_CORNER, 1'b1, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    send_word(OP_CORNER, 1'b0, 20'h0, 20'h0, 20'h0);
    send_word(OP_CORNER, 1'b0, 20'hAAAAA, 20'h55555, 20'h12345);
    send_word(OP_CORNER, 1'b0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    // repeated corner within one triangle
    send_word(OP_CORNER, 1'b1, 20'h1, 20'h1, 20'h1);
    send_word(OP_CORNER, 1'b0, 20'h1, 20'h1, 20'h1);
    send_word(OP_CORNER, 1'b0, 20'h1, 20'h1, 20'h1);
    // end of object, then a corner without a started face
    send_word(OP_END, 1'b1, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    send_word(OP_CORNER, 1'b0, 20'h55555, 20'hAAAAA, 20'h0);
    send_word(OP_CORNER, 1'b0, 20'h2, 20'h0, 20'h3);
    send_word(OP_CORNER, 1'b0, 20'h0, 20'h0, 20'h0);

    // Directed: flat mode, then indexed again mid-object
    write_mode(1'b1);
    send_word(OP_CORNER, 1'b1, 20'h7, 20'h8, 20'h9);
    send_word(OP_CORNER, 1'b0, 20'h7, 20'h8, 20'h9);
    send_word(OP_CORNER, 1'b0, 20'h0, 20'h0, 20'h0);
    write_mode(1'b0);
    send_word(OP_CORNER, 1'b1, 20'h7, 20'h8, 20'h9);
    send_word(OP_CORNER, 1'b0, 20'h0, 20'h0, 20'h0);
    send_word(OP_CORNER, 1'b0, 20'h55555, 20'hAAAAA, 20'h0);

    // Random phases with different idling
    send_idle_pct = 38;
    recv_idle_pct = 58;
    random_corners(70);
    write_mode(1'b1);
    send_idle_pct = 58;
    recv_idle_pct = 38;
    random_corners(65);
    write_mode(1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_corners(65);

    drain();
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
